/* rtl/core/nmea_gga_sentence_parser_defines.svh */
// assertion macros shared by the gga parser rtl
`ifndef NMEA_GGA_SENTENCE_PARSER_DEFINES_SVH
`define NMEA_GGA_SENTENCE_PARSER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NGGA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define NGGA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ngga_pkg.sv */
// types and constants of the gga sentence parser
package ngga_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_W     = 8'h57;

  localparam logic [4:0] HOUR_OFFSET_RESET = 5'd16;
  localparam int unsigned TIME_DIGITS = 6;

  // comma-counted field numbers
  localparam logic [3:0] FLD_TIME = 4'd1;
  localparam logic [3:0] FLD_LAT  = 4'd2;
  localparam logic [3:0] FLD_NS   = 4'd3;
  localparam logic [3:0] FLD_LON  = 4'd4;
  localparam logic [3:0] FLD_EW   = 4'd5;
  localparam logic [3:0] FLD_SATS = 4'd7;
  localparam logic [3:0] FLD_MAX  = 4'd15;

  // sentence character positions
  localparam logic [2:0] POS_TYPE0 = 3'd3;
  localparam logic [2:0] POS_TYPE1 = 3'd4;
  localparam logic [2:0] POS_TYPE2 = 3'd5;
  localparam logic [2:0] POS_MIN_LEN = 3'd6;
  localparam logic [2:0] POS_MAX  = 3'd7;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_HEX_LETTER,
    CLS_DOLLAR,
    CLS_CR,
    CLS_COMMA,
    CLS_STAR,
    CLS_DOT,
    CLS_OTHER
  } ngga_cls_t;

  typedef struct packed {
    logic [7:0] raw;
    ngga_cls_t  cls;
    logic [3:0] nib;
  } ngga_item_t;

  typedef struct packed {
    logic              head_valid;
    logic [QCNT_W-1:0] count;
  } ngga_qstat_t;

endpackage

/* rtl/core/nmea_gga_sentence_parser.sv */
// top level of the gga sentence parser
//
//  channel  direction  handshake           payload
//  in       input      in_valid/in_stall   in_rx_byte
//  out      output     out_valid/out_stall out_local_hours .. out_format_error
//  cfg      input      cfg_valid/cfg_ready cfg_hour_offset
//
// one byte per cycle while in_stall is low; a byte taken at one edge is parsed in the
// next cycle when the queue is empty and no result is held by out_stall, and a result is
// registered at the end of the cycle that parses its carriage return
// a result held by out_stall stops the parser; the four-word queue then fills
// and raises in_stall
// synchronous active-low reset clears the queue, sentence flag and result
// valid, and sets the hour offset to 16; cfg writes are always taken
`include "nmea_gga_sentence_parser_defines.svh"

module nmea_gga_sentence_parser
  import ngga_pkg::*;
#(
  parameter int unsigned LAT_DIGITS = 8,
  parameter int unsigned LON_DIGITS = 9
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_rx_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [4:0]              out_local_hours,
  output logic [6:0]              out_minutes,
  output logic [6:0]              out_seconds,
  output logic [4*LAT_DIGITS-1:0] out_latitude_bcd,
  output logic                    out_latitude_south,
  output logic [4*LON_DIGITS-1:0] out_longitude_bcd,
  output logic                    out_longitude_west,
  output logic [6:0]              out_satellites_used,
  output logic [7:0]              out_sent_checksum,
  output logic                    out_format_error,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [4:0]              cfg_hour_offset
);

  ngga_item_t  q_head;
  ngga_qstat_t q_stat;
  logic        q_pop;
  logic        push;
  logic        dec_ok;

  assign cfg_ready = 1'b1;

  ngga_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_rx_byte(in_rx_byte),
    .q_pop     (q_pop),
    .q_head    (q_head),
    .q_stat    (q_stat)
  );

  ngga_back #(
    .LAT_DIGITS(LAT_DIGITS),
    .LON_DIGITS(LON_DIGITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_head             (q_head),
    .q_stat             (q_stat),
    .q_pop              (q_pop),
    .cfg_valid          (cfg_valid && cfg_ready),
    .cfg_hour_offset    (cfg_hour_offset),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_local_hours    (out_local_hours),
    .out_minutes        (out_minutes),
    .out_seconds        (out_seconds),
    .out_latitude_bcd   (out_latitude_bcd),
    .out_latitude_south (out_latitude_south),
    .out_longitude_bcd  (out_longitude_bcd),
    .out_longitude_west (out_longitude_west),
    .out_satellites_used(out_satellites_used),
    .out_sent_checksum  (out_sent_checksum),
    .out_format_error   (out_format_error)
  );

  assign push   = in_valid && !in_stall && (in_rx_byte != CH_NUL);
  assign dec_ok = (out_minutes < 7'd100) && (out_seconds < 7'd100) &&
                  (out_satellites_used < 7'd100);

  `NGGA_ASSERT_IMPLY(a_hours_range, clk, rst_n, out_valid, out_local_hours < 5'd24, "bad hours")
  `NGGA_ASSERT_IMPLY(a_decimal_range, clk, rst_n, out_valid, dec_ok, "bad decimal field")
  `NGGA_ASSERT_IMPLY(a_pop_has_word, clk, rst_n, q_pop, q_stat.head_valid, "empty pop")
  `NGGA_ASSERT_NEXT(a_push_lands, clk, rst_n, push && !q_pop, q_stat.count != '0, "push lost")

endmodule

/* rtl/core/ngga_front.sv */
// byte classifier and word queue feeding the sentence parser
module ngga_front
  import ngga_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        q_pop,
  output ngga_item_t  q_head,
  output ngga_qstat_t q_stat
);

  ngga_item_t        item;
  ngga_item_t        store_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;

  always_comb begin
    item.raw = in_rx_byte;
    item.nib = in_rx_byte[3:0];
    if (in_rx_byte inside {[CH_ZERO:CH_NINE]}) begin
      item.cls = CLS_DIGIT;
    end else if (in_rx_byte inside {[CH_UP_A:CH_UP_F], [CH_LO_A:CH_LO_F]}) begin
      item.cls = CLS_HEX_LETTER;
      item.nib = in_rx_byte[3:0] + 4'd9;
    end else if (in_rx_byte == CH_DOLLAR) begin
      item.cls = CLS_DOLLAR;
    end else if (in_rx_byte == CH_CR) begin
      item.cls = CLS_CR;
    end else if (in_rx_byte == CH_COMMA) begin
      item.cls = CLS_COMMA;
    end else if (in_rx_byte == CH_STAR) begin
      item.cls = CLS_STAR;
    end else if (in_rx_byte == CH_DOT) begin
      item.cls = CLS_DOT;
    end else begin
      item.cls = CLS_OTHER;
    end
  end

  assign in_stall = (count_r == QCNT_W'(QUEUE_DEPTH));
  // null bytes are taken and dropped here
  assign push = in_valid && !in_stall && (in_rx_byte != CH_NUL);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= item;
    end
  end

  assign q_head            = store_r[rd_ptr_r];
  assign q_stat.head_valid = (count_r != '0);
  assign q_stat.count      = count_r;

endmodule

/* rtl/core/ngga_back.sv */
// sentence tracker, field capture and result register
module ngga_back
  import ngga_pkg::*;
#(
  parameter int unsigned LAT_DIGITS = 8,
  parameter int unsigned LON_DIGITS = 9
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ngga_item_t              q_head,
  input  ngga_qstat_t             q_stat,
  output logic                    q_pop,
  input  logic                    cfg_valid,
  input  logic [4:0]              cfg_hour_offset,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [4:0]              out_local_hours,
  output logic [6:0]              out_minutes,
  output logic [6:0]              out_seconds,
  output logic [4*LAT_DIGITS-1:0] out_latitude_bcd,
  output logic                    out_latitude_south,
  output logic [4*LON_DIGITS-1:0] out_longitude_bcd,
  output logic                    out_longitude_west,
  output logic [6:0]              out_satellites_used,
  output logic [7:0]              out_sent_checksum,
  output logic                    out_format_error
);

  localparam int unsigned LAT_W  = 4 * LAT_DIGITS;
  localparam int unsigned LON_W  = 4 * LON_DIGITS;
  localparam int unsigned TIME_W = 4 * TIME_DIGITS;

  logic [4:0]        offset_r;
  logic              in_sent_r, in_sent_nxt;
  logic [2:0]        pos_r, pos_nxt;
  logic              type_r, type_nxt;
  logic [3:0]        fld_r, fld_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [LAT_W-1:0]  lat_r, lat_nxt;
  logic [LON_W-1:0]  lon_r, lon_nxt;
  logic              south_r, south_nxt;
  logic              west_r, west_nxt;
  logic [6:0]        sats_r, sats_nxt;
  logic              star_r, star_nxt;
  logic [7:0]        cks_r, cks_nxt;
  logic              err_r, err_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              emit;
  logic              is_digit, is_hex;
  logic [6:0]        hrs, mins, secs;
  logic [7:0]        hour_sum;

  function automatic logic [4:0] mod24(input logic [7:0] s);
    logic [7:0] r;
    if (s >= 8'd120) begin
      r = s - 8'd120;
    end else if (s >= 8'd96) begin
      r = s - 8'd96;
    end else if (s >= 8'd72) begin
      r = s - 8'd72;
    end else if (s >= 8'd48) begin
      r = s - 8'd48;
    end else if (s >= 8'd24) begin
      r = s - 8'd24;
    end else begin
      r = s;
    end
    return r[4:0];
  endfunction

  // take a word only when the result slot is free or being emptied
  assign q_pop    = q_stat.head_valid && (!out_valid_r || !out_stall);
  assign is_digit = (q_head.cls == CLS_DIGIT);
  assign is_hex   = is_digit || (q_head.cls == CLS_HEX_LETTER);

  always_comb begin
    in_sent_nxt = in_sent_r;
    pos_nxt     = pos_r;
    type_nxt    = type_r;
    fld_nxt     = fld_r;
    cnt_nxt     = cnt_r;
    time_nxt    = time_r;
    lat_nxt     = lat_r;
    lon_nxt     = lon_r;
    south_nxt   = south_r;
    west_nxt    = west_r;
    sats_nxt    = sats_r;
    star_nxt    = star_r;
    cks_nxt     = cks_r;
    err_nxt     = err_r;
    emit        = 1'b0;
    if (q_pop) begin
      if (!in_sent_r) begin
        if (q_head.cls == CLS_DOLLAR) begin
          in_sent_nxt = 1'b1;
          pos_nxt     = 3'd1;
          type_nxt    = 1'b1;
          fld_nxt     = '0;
          cnt_nxt     = '0;
          time_nxt    = '0;
          lat_nxt     = '0;
          lon_nxt     = '0;
          south_nxt   = 1'b0;
          west_nxt    = 1'b0;
          sats_nxt    = '0;
          star_nxt    = 1'b0;
          cks_nxt     = '0;
          err_nxt     = 1'b0;
        end
      end else if (q_head.cls == CLS_CR) begin
        in_sent_nxt = 1'b0;
        emit        = type_r && (pos_r >= POS_MIN_LEN);
      end else begin
        // sentence type check on the three letters after the talker id
        if ((pos_r == POS_TYPE0) || (pos_r == POS_TYPE1)) begin
          if (q_head.raw != CH_G) begin
            type_nxt = 1'b0;
          end
        end else if (pos_r == POS_TYPE2) begin
          if (q_head.raw != CH_A) begin
            type_nxt = 1'b0;
          end
        end
        if (pos_r < POS_MAX) begin
          pos_nxt = pos_r + 3'd1;
        end

        if (star_r) begin
          if (!is_hex) begin
            err_nxt = 1'b1;
          end else if (cnt_r < 4'd2) begin
            cks_nxt = {cks_r[3:0], q_head.nib};
            cnt_nxt = cnt_r + 4'd1;
          end
        end else if (q_head.cls == CLS_COMMA) begin
          if (fld_r < FLD_MAX) begin
            fld_nxt = fld_r + 4'd1;
          end
          cnt_nxt = '0;
        end else if (q_head.cls == CLS_STAR) begin
          star_nxt = 1'b1;
          cnt_nxt  = '0;
        end else begin
          case (fld_r)
            FLD_TIME: begin
              if (is_digit) begin
                for (int i = 0; i < TIME_DIGITS; i++) begin
                  if (cnt_r == 4'(i)) begin
                    time_nxt[4*(TIME_DIGITS-1-i) +: 4] = q_head.nib;
                  end
                end
                if (cnt_r < 4'(TIME_DIGITS)) begin
                  cnt_nxt = cnt_r + 4'd1;
                end
              end else if (q_head.cls != CLS_DOT) begin
                err_nxt = 1'b1;
              end
            end
            FLD_LAT: begin
              if (is_digit) begin
                for (int i = 0; i < LAT_DIGITS; i++) begin
                  if (cnt_r == 4'(i)) begin
                    lat_nxt[4*(LAT_DIGITS-1-i) +: 4] = q_head.nib;
                  end
                end
                if (cnt_r < 4'(LAT_DIGITS)) begin
                  cnt_nxt = cnt_r + 4'd1;
                end
              end else if (q_head.cls != CLS_DOT) begin
                err_nxt = 1'b1;
              end
            end
            FLD_NS: begin
              if (q_head.raw == CH_S) begin
                south_nxt = 1'b1;
              end else if (q_head.raw != CH_N) begin
                err_nxt = 1'b1;
              end
            end
            FLD_LON: begin
              if (is_digit) begin
                for (int i = 0; i < LON_DIGITS; i++) begin
                  if (cnt_r == 4'(i)) begin
                    lon_nxt[4*(LON_DIGITS-1-i) +: 4] = q_head.nib;
                  end
                end
                if (cnt_r < 4'(LON_DIGITS)) begin
                  cnt_nxt = cnt_r + 4'd1;
                end
              end else if (q_head.cls != CLS_DOT) begin
                err_nxt = 1'b1;
              end
            end
            FLD_EW: begin
              if (q_head.raw == CH_W) begin
                west_nxt = 1'b1;
              end else if (q_head.raw != CH_E) begin
                err_nxt = 1'b1;
              end
            end
            FLD_SATS: begin
              if (is_digit) begin
                if (cnt_r < 4'd2) begin
                  sats_nxt = (sats_r << 3) + (sats_r << 1) + 7'(q_head.nib);
                  cnt_nxt  = cnt_r + 4'd1;
                end
              end else begin
                err_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  // time digits are decimal, so each pair stays below 100
  always_comb begin
    hrs      = 7'(time_r[23:20]) * 7'd10 + 7'(time_r[19:16]);
    mins     = 7'(time_r[15:12]) * 7'd10 + 7'(time_r[11:8]);
    secs     = 7'(time_r[7:4]) * 7'd10 + 7'(time_r[3:0]);
    hour_sum = 8'(hrs) + 8'(offset_r);
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= HOUR_OFFSET_RESET;
      in_sent_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        offset_r <= cfg_hour_offset;
      end
      in_sent_r   <= in_sent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // capture state is cleared when a sentence opens
  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    type_r  <= type_nxt;
    fld_r   <= fld_nxt;
    cnt_r   <= cnt_nxt;
    time_r  <= time_nxt;
    lat_r   <= lat_nxt;
    lon_r   <= lon_nxt;
    south_r <= south_nxt;
    west_r  <= west_nxt;
    sats_r  <= sats_nxt;
    star_r  <= star_nxt;
    cks_r   <= cks_nxt;
    err_r   <= err_nxt;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_local_hours     <= mod24(hour_sum);
      out_minutes         <= mins;
      out_seconds         <= secs;
      out_latitude_bcd    <= lat_r;
      out_latitude_south  <= south_r;
      out_longitude_bcd   <= lon_r;
      out_longitude_west  <= west_r;
      out_satellites_used <= sats_r;
      out_sent_checksum   <= cks_r;
      out_format_error    <= err_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
